/* src/swdb_pkg.sv */
`default_nettype none

package swdb_pkg;

    localparam int BYTE_W         = 8;
    localparam int SYMBOLS        = 256;
    localparam int COUNT_W        = 9;
    localparam int DEFAULT_WINDOW = 256;

    // One byte on its way from the ring stage to the tracking stage.
    typedef struct packed {
        logic [BYTE_W-1:0] sym;      // byte entering the window
        logic [BYTE_W-1:0] old_sym;  // byte leaving the window (valid when full)
        logic              start;    // first byte of a new image
        logic              full;     // window was full before this byte
        logic              emit;     // window is full after this byte
    } item_t;

endpackage

`default_nettype wire

/* src/swdb_tracker.sv */
`default_nettype none

module swdb_tracker import swdb_pkg::*; #(
    parameter int  WINDOW = DEFAULT_WINDOW,
    localparam int PTR_W  = $clog2(WINDOW)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s1_valid,
    input  wire item_t              s1_item,
    input  wire logic [PTR_W-1:0]   s1_pos,
    output logic                    advance,
    output logic [COUNT_W-1:0]      distinct_count,
    output logic                    count_valid,
    input  wire logic               count_ready
);

    // Ring position of the latest occurrence of each byte value
    logic [PTR_W-1:0]   stamp_mem [SYMBOLS];
    logic [PTR_W-1:0]   stamp_rdata_reg;
    logic               fwd_hit_reg;
    logic [PTR_W-1:0]   fwd_stamp_reg;

    logic               s2_valid_reg;
    item_t              s2_item_reg;
    logic [PTR_W-1:0]   s2_pos_reg;

    logic [SYMBOLS-1:0] present_reg;
    logic [SYMBOLS-1:0] present_next;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic [COUNT_W-1:0] count_reg;
    logic               count_valid_reg;

    logic [SYMBOLS-1:0] valid_base;
    logic [SYMBOLS-1:0] valid_after;
    logic [COUNT_W-1:0] total_base;
    logic [PTR_W-1:0]   old_stamp;
    logic               expire;
    logic               seen;

    assign advance = !(s2_valid_reg && s2_item_reg.emit && count_valid_reg && !count_ready);

    always_comb
    begin
        valid_base  = s2_item_reg.start ? '0 : present_reg;
        total_base  = s2_item_reg.start ? '0 : total_reg;
        old_stamp   = fwd_hit_reg ? fwd_stamp_reg : stamp_rdata_reg;
        // the leaving byte drops out unless it occurs again later in the window
        expire      = s2_item_reg.full && valid_base[s2_item_reg.old_sym]
                      && (old_stamp == s2_pos_reg);
        valid_after = valid_base;
        if (expire)
        begin
            valid_after[s2_item_reg.old_sym] = 1'b0;
        end
        seen         = valid_after[s2_item_reg.sym];
        present_next = valid_after;
        present_next[s2_item_reg.sym] = 1'b1;
        total_next   = total_base - COUNT_W'(expire) + COUNT_W'(!seen);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stamp_rdata_reg <= stamp_mem[s1_item.old_sym];
            fwd_stamp_reg   <= s2_pos_reg;
            s2_item_reg     <= s1_item;
            s2_pos_reg      <= s1_pos;
            if (s2_valid_reg)
            begin
                stamp_mem[s2_item_reg.sym] <= s2_pos_reg;
            end
            if (s2_valid_reg && s2_item_reg.emit)
            begin
                count_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            present_reg     <= '0;
            total_reg       <= '0;
            count_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s2_valid_reg <= s1_valid;
                // bypass the stamp being written in the same cycle
                fwd_hit_reg  <= s2_valid_reg && (s2_item_reg.sym == s1_item.old_sym);
                if (s2_valid_reg)
                begin
                    present_reg <= present_next;
                    total_reg   <= total_next;
                end
            end
            if (advance && s2_valid_reg && s2_item_reg.emit)
            begin
                count_valid_reg <= 1'b1;
            end
            else if (count_ready)
            begin
                count_valid_reg <= 1'b0;
            end
        end
    end

    assign distinct_count = count_reg;
    assign count_valid    = count_valid_reg;

endmodule

`default_nettype wire

/* src/sliding_window_distinct_bytes.sv */
`default_nettype none

// Sliding-window distinct byte counter. Each byte transfer on the byte channel
// enters a window of the last WINDOW bytes; once the window is full, every byte
// yields one result on the count channel: the number of different byte values
// in the window (1 to 256). start_of_image marks the first byte of a new image
// and restarts the window, so results resume after WINDOW bytes of that image.
// The block takes one byte per clock cycle unless byte_ready is low; results pass
// the ring, tracking and output registers. That rate is set by the stamp memory
// (256 entries, last ring position of each byte value), read for the leaving byte
// and written for the entering byte in each cycle, with a bypass for back-to-back
// use of the same entry. byte_ready drops only while a finished result sits in
// the tracking stage behind an output register that is still waiting. Per-value
// presence bits live in flops, so reset and start_of_image need no clearing pass.

module sliding_window_distinct_bytes import swdb_pkg::*; #(
    parameter int  WINDOW = DEFAULT_WINDOW,
    localparam int PTR_W  = $clog2(WINDOW),
    localparam int FILL_W = $clog2(WINDOW + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic               start_of_image,
    output logic                    count_valid,
    input  wire logic               count_ready,
    output logic [COUNT_W-1:0]      distinct_count
);

    // Ring of the window's bytes; a read entry is used only after being written
    logic [BYTE_W-1:0]  ring_mem [WINDOW];
    logic [BYTE_W-1:0]  ring_rdata_reg;

    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    logic               s1_valid_reg;
    logic [BYTE_W-1:0]  s1_sym_reg;
    logic               s1_start_reg;
    logic               s1_full_reg;
    logic               s1_emit_reg;
    logic [PTR_W-1:0]   s1_pos_reg;

    logic               advance;
    logic               accept;
    logic [PTR_W-1:0]   pos;
    logic               full_before;
    item_t              s1_item;

    assign byte_ready = advance;
    assign accept     = byte_valid && advance;

    // Restart at position zero with an empty window on a new image
    always_comb
    begin
        pos         = start_of_image ? '0 : ptr_reg;
        full_before = !start_of_image && (fill_reg == FILL_W'(WINDOW));
        if (start_of_image)
        begin
            fill_next = FILL_W'(1);
        end
        else if (full_before)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        ptr_next = (pos == PTR_W'(WINDOW - 1)) ? '0 : pos + PTR_W'(1);
    end

    // Read the leaving byte and write the entering one at the same slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_rdata_reg <= ring_mem[pos];
            ring_mem[pos]  <= data_byte;
            s1_sym_reg     <= data_byte;
            s1_start_reg   <= start_of_image;
            s1_full_reg    <= full_before;
            s1_emit_reg    <= (fill_next == FILL_W'(WINDOW));
            s1_pos_reg     <= pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ptr_reg  <= ptr_next;
                fill_reg <= fill_next;
            end
            if (advance)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_comb
    begin
        s1_item.sym     = s1_sym_reg;
        s1_item.old_sym = ring_rdata_reg;
        s1_item.start   = s1_start_reg;
        s1_item.full    = s1_full_reg;
        s1_item.emit    = s1_emit_reg;
    end

    // Track presence per byte value and the running distinct total
    swdb_tracker #(
        .WINDOW         (WINDOW)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid_reg),
        .s1_item        (s1_item),
        .s1_pos         (s1_pos_reg),
        .advance        (advance),
        .distinct_count (distinct_count),
        .count_valid    (count_valid),
        .count_ready    (count_ready)
    );

    // A reported window always holds at least one and at most 256 values
    assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> (distinct_count != '0) && (distinct_count <= COUNT_W'(SYMBOLS)))
        else $error("distinct count out of range");

    // A new image restarts the window with exactly one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && start_of_image) |=> (fill_reg == FILL_W'(1)) && (ptr_reg == PTR_W'(1)))
        else $error("window not restarted on start of image");

    // Until the window fills, the ring position tracks the fill level
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != FILL_W'(WINDOW)) |-> (ptr_reg == fill_reg[PTR_W-1:0]))
        else $error("ring position and fill level disagree");

    // The fill level never passes the window size
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill level beyond window");

endmodule

`default_nettype wire

/* test/tb_sliding_window_distinct_bytes.sv */
`timescale 1ns / 1ps

module tb_sliding_window_distinct_bytes import swdb_pkg::*;;

    // The predictor tracks the same window length as the default instance.
    localparam int WIN = DEFAULT_WINDOW;
    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Settle time after the last expected count.
    localparam int SETTLE_CYCLES = 8;

    // Content patterns for stretches of the byte stream.
    typedef enum int {
        STYLE_UNIFORM,  // any byte value
        STYLE_NARROW,   // four neighboring values, so counts climb above one
        STYLE_SINGLE,   // one value repeated
        STYLE_RAMP      // rising values; a ramp of WIN bytes gives every value once
    } fill_style_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              sof;
    } byte_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_ready;
    logic [BYTE_W-1:0]  data_byte = '0;
    logic               start_of_image = 1'b0;
    logic               count_valid;
    logic               count_ready = 1'b0;
    logic [COUNT_W-1:0] distinct_count;

    // Bytes waiting to be driven, and counts waiting to come out.
    byte_item_t         pending_bytes[$];
    logic [COUNT_W-1:0] expected_counts[$];

    // Predictor state: window contents, hits per byte value, distinct total,
    // fill level and write position.
    logic [BYTE_W-1:0]  win_bytes [WIN];
    logic [COUNT_W-1:0] value_hits [SYMBOLS];
    logic [COUNT_W-1:0] distinct_now = '0;
    int                 fill_now = 0;
    int                 wr_pos = 0;

    // Percent of cycles in which each side holds off.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    bit byte_done = 1'b0;
    int error_count = 0;
    int bytes_taken = 0;
    int counts_checked = 0;
    int images_started = 1;  // the stream after reset counts as one image
    int quiet_cycles = 0;

    sliding_window_distinct_bytes uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .data_byte      (data_byte),
        .start_of_image (start_of_image),
        .count_valid    (count_valid),
        .count_ready    (count_ready),
        .distinct_count (distinct_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        foreach (value_hits[v])
        begin
            value_hits[v] = '0;
        end
    end

    // Advance the window by one byte and report the distinct count if the
    // window is full afterwards. A start flag clears the window first, so the
    // flagged byte becomes the first byte of the new image.
    task automatic advance_window(input logic [BYTE_W-1:0] b, input logic sof,
                                  output bit has_count, output logic [COUNT_W-1:0] count);
        logic [BYTE_W-1:0] leaving;
        if (sof)
        begin
            foreach (value_hits[v])
            begin
                value_hits[v] = '0;
            end
            distinct_now = '0;
            fill_now = 0;
            wr_pos = 0;
        end
        // Drop the byte that leaves a full window; when it equals the new
        // byte, its hit count goes down and back up, leaving the total as is.
        if (fill_now >= WIN)
        begin
            leaving = win_bytes[wr_pos];
            if (value_hits[leaving] != 0)
            begin
                value_hits[leaving] = value_hits[leaving] - 1'b1;
                if (value_hits[leaving] == 0 && distinct_now != 0)
                begin
                    distinct_now = distinct_now - 1'b1;
                end
            end
        end
        win_bytes[wr_pos] = b;
        if (value_hits[b] == 0)
        begin
            distinct_now = distinct_now + 1'b1;
        end
        if (value_hits[b] < WIN)
        begin
            value_hits[b] = value_hits[b] + 1'b1;
        end
        wr_pos = (wr_pos + 1) % WIN;
        if (fill_now < WIN)
        begin
            fill_now++;
        end
        has_count = (fill_now >= WIN);
        count = distinct_now;
    endtask

    task automatic push_segment(input fill_style_t style, input int len, input bit first_sof);
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] b;
        base = BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            case (style)
                STYLE_UNIFORM: b = BYTE_W'($urandom_range(0, 255));
                STYLE_NARROW:  b = base + BYTE_W'($urandom_range(0, 3));
                STYLE_SINGLE:  b = base;
                default:       b = base + BYTE_W'(i);
            endcase
            pending_bytes.push_back('{b, first_sof && i == 0});
        end
    endtask

    // Queue a run of bytes made of short stretches in random patterns.
    task automatic push_mixed(input int total, input bit first_sof);
        int remaining;
        int len;
        bit first;
        remaining = total;
        first = 1'b1;
        while (remaining > 0)
        begin
            len = int'($urandom_range(8, 64));
            if (len > remaining)
            begin
                len = remaining;
            end
            push_segment(fill_style_t'($urandom_range(0, 3)), len, first_sof && first);
            remaining -= len;
            first = 1'b0;
        end
    endtask

    // Queue images that restart before the window fills, down to a single
    // byte, so start flags also land on consecutive bytes.
    task automatic push_broken_images(input int n);
        for (int k = 0; k < n; k++)
        begin
            push_mixed((k == 0) ? 1 : int'($urandom_range(1, 40)), 1'b1);
        end
    endtask

    // Hold the sender until every queued byte is taken and every expected
    // count has come out, then let the pipeline settle.
    task automatic wait_for_counts_drained();
        while (pending_bytes.size() != 0 || byte_valid)
        begin
            @(posedge clk);
        end
        while (expected_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: present bytes from the pending queue at the falling edge.
    // Hold the payload until the transfer, and idle at random between items.
    always @(negedge clk)
    begin
        byte_item_t next_item;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            count_ready <= 1'b0;
        end
        else
        begin
            count_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!byte_valid || byte_done)
            begin
                byte_done = 1'b0;
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    data_byte <= next_item.data;
                    start_of_image <= next_item.sof;
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: at the rising edge, predict on each byte transfer and check
    // each count transfer against the oldest expected count.
    always @(posedge clk)
    begin
        bit has_count;
        logic [COUNT_W-1:0] want;
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                advance_window(data_byte, start_of_image, has_count, want);
                if (has_count)
                begin
                    expected_counts.push_back(want);
                end
                byte_done = 1'b1;
                bytes_taken++;
                if (start_of_image)
                begin
                    images_started++;
                end
            end
            if (count_valid && count_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: unexpected count %0d with no count expected",
                             $time, distinct_count);
                    error_count++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    counts_checked++;
                    if (distinct_count !== want)
                    begin
                        $display("%0t: distinct_count mismatch, expected %0d, got %0d",
                                 $time, want, distinct_count);
                        error_count++;
                    end
                end
            end
            // Watchdog: give up after a long stretch with no transfer at all.
            if ((byte_valid && byte_ready) || (count_valid && count_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender idles often, receiver idles more.
        send_idle_pct = 35;
        recv_idle_pct = 64;

        // Directed bytes: field extremes and repeats, no start flag, so the
        // stream from reset is one image.
        pending_bytes.push_back('{8'h00, 1'b0});
        pending_bytes.push_back('{8'hFF, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b0});
        pending_bytes.push_back('{8'h80, 1'b0});
        pending_bytes.push_back('{8'h7F, 1'b0});
        pending_bytes.push_back('{8'h55, 1'b0});
        pending_bytes.push_back('{8'hAA, 1'b0});
        pending_bytes.push_back('{8'h01, 1'b0});
        pending_bytes.push_back('{8'hFE, 1'b0});
        pending_bytes.push_back('{8'hFF, 1'b0});
        pending_bytes.push_back('{8'hFF, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b0});
        // Pause the sender mid-image until the pipeline is empty.
        wait_for_counts_drained();

        // Continue the unflagged image with a ramp past a full window. The
        // window ends up holding every value, and once the ramp wraps
        // each new byte equals the one leaving the window.
        push_segment(STYLE_RAMP, 260, 1'b0);
        wait_for_counts_drained();

        // Phase two: pacing swapped; mixed content slides over the full window.
        send_idle_pct = 64;
        recv_idle_pct = 35;
        push_mixed(40, 1'b0);
        wait_for_counts_drained();

        // Phase three: no idling. More sliding, then images that restart
        // before they fill.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_mixed(40, 1'b0);
        push_broken_images(3);
        wait_for_counts_drained();

        $display("Covered %0d byte transfers over %0d images and %0d checked counts,",
                 bytes_taken, images_started, counts_checked);
        $display("with sender and receiver idling in turn and then at full rate.");
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
